@@ rtl/sampled_lru_stack_distance_monitor_macros.svh @@
// Assertion macros shared by the sampled LRU stack distance monitor RTL.
`ifndef SAMPLED_LRU_STACK_DISTANCE_MONITOR_MACROS_SVH
`define SAMPLED_LRU_STACK_DISTANCE_MONITOR_MACROS_SVH
// Same-cycle implication, checked on clk, disabled while rst_n is low.
`define SLSD_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication, checked on clk, disabled while rst_n is low.
`define SLSD_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`endif

@@ rtl/slsd_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and constants for the sampled LRU stack distance monitor.
package slsd_pkg;

  localparam int unsigned TAG_W = 48;
  localparam int unsigned CNT_W = 48;
  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

  localparam logic KIND_ACCESS = 1'b0;
  localparam logic KIND_CURVE  = 1'b1;

  typedef enum logic [1:0] {
    OP_ACCESS     = 2'd0,
    OP_READ_CURVE = 2'd1,
    OP_CLEAR      = 2'd2
  } op_t;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_LOOKUP,
    ST_HUPD,
    ST_EMIT,
    ST_CSUM,
    ST_CEMIT
  } state_t;

  typedef struct packed {
    logic [1:0]  operation;
    logic [47:0] line_addr;
    logic [31:0] sample_hash;
    logic [31:0] set_hash;
  } slsd_in_t;

  typedef struct packed {
    logic        kind;
    logic        sampled;
    logic        hit;
    logic [3:0]  stack_position;
    logic [4:0]  curve_index;
    logic [47:0] curve_value;
    logic        last;
  } slsd_out_t;

endpackage

@@ rtl/sampled_lru_stack_distance_monitor.sv @@
`timescale 1ns / 1ps
// Sampled LRU stack distance monitor top level.
//
// A sampled shadow tag array of SETS sets by WAYS ways, each set one row of a
// tag/rank RAM, profiles hits by LRU stack position; a second RAM of WAYS
// entries holds the 48-bit saturating position counters. Work per item is
// set by these two RAM ports: an unsampled access is answered from idle, a
// sampled miss does a row read, then compare and write-back, a sampled hit
// adds the counter read-modify-write. A miss curve read makes two passes:
// one sums all counters, a second streams the WAYS+1 entries, one per cycle
// while out_stall is low. A clear gives no item. Accesses never overlap in
// the RAMs, so no forwarding is needed. After reset the block writes every
// set to zero tags and identity ranks, one set a cycle, holding in_stall high
// until the last set is written; cfg writes are taken at any time.
`include "sampled_lru_stack_distance_monitor_macros.svh"
module sampled_lru_stack_distance_monitor
  import slsd_pkg::*;
#(
  parameter int unsigned WAYS = 16,
  parameter int unsigned SETS = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  slsd_in_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output slsd_out_t out_data,
  input  logic      cfg_wr_en,
  input  logic [4:0] cfg_wr_data
);

  localparam int unsigned PW    = $clog2(WAYS);
  localparam int unsigned KW    = $clog2(WAYS + 1);
  localparam int unsigned TW    = CNT_W + KW;
  localparam int unsigned RB    = WAYS * TAG_W;
  localparam int unsigned ROW_W = WAYS * (TAG_W + PW);
  localparam int unsigned SAW   = (SETS > 1) ? $clog2(SETS) : 1;
  localparam int unsigned SBITS = $clog2(SETS + 1) - 1;
  localparam logic [31:0] SET_MASK = (32'd1 << SBITS) - 32'd1;
  localparam logic [KW-1:0]  K_LAST   = KW'(WAYS);
  localparam logic [SAW-1:0] INIT_END = SAW'(SETS - 1);

  state_t            state_r, state_nxt;
  logic [SAW-1:0]    init_r, init_nxt;
  logic [4:0]        samp_bits_r, samp_bits_nxt;
  logic [CNT_W-1:0]  miss_r, miss_nxt;
  logic [WAYS-1:0]   hvld_r, hvld_nxt;
  logic [KW-1:0]     cnt_r, cnt_nxt;
  logic [TW-1:0]     rem_r, rem_nxt;
  logic [TAG_W-1:0]  addr_r, addr_nxt;
  logic [SAW-1:0]    set_r, set_nxt;
  logic [PW-1:0]     pos_r, pos_nxt;
  slsd_out_t         res_r, res_nxt;
  logic [PW-1:0]     hit_ra_r;
  logic              out_valid_r;
  slsd_out_t         out_data_r;

  logic              in_accept;
  op_t               op_in;
  logic [31:0]       smask;
  logic              smp_in;
  logic [31:0]       set_m;
  logic [SAW-1:0]    set_in;
  logic              out_free;
  logic              emit;
  slsd_out_t         emit_data;

  logic              tag_we, tag_re;
  logic [SAW-1:0]    tag_waddr;
  logic [ROW_W-1:0]  tag_wdata, tag_rdata, init_row;
  logic              hit_we, hit_re;
  logic [PW-1:0]     hit_waddr, hit_raddr;
  logic [CNT_W-1:0]  hit_wdata, hit_rdata, hval;

  logic              lk_hit;
  logic [PW-1:0]     lk_pos;
  logic [WAYS-1:0]   lk_vic;
  logic [ROW_W-1:0]  lk_row;
  logic [31:0]       pos_ext, k_ext;
  slsd_out_t         nsmp_res, lk_res, curve_res;

  assign in_stall  = (state_r != ST_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign op_in     = op_t'(in_data.operation);
  assign smask     = ~(32'hFFFF_FFFF << samp_bits_r);
  assign smp_in    = ((in_data.sample_hash & smask) == 32'd0);
  assign set_m     = in_data.set_hash & SET_MASK;
  assign set_in    = set_m[SAW-1:0];
  assign out_free  = !out_valid_r || !out_stall;
  assign hval      = hvld_r[hit_ra_r] ? hit_rdata : '0;

  assign samp_bits_nxt = cfg_wr_en ? cfg_wr_data : samp_bits_r;

  always_comb begin
    init_row = '0;
    for (int w = 0; w < WAYS; w++) begin
      init_row[RB + w*PW +: PW] = PW'(w);
    end
  end

  slsd_ram #(
    .WIDTH(ROW_W),
    .DEPTH(SETS)
  ) u_tag_ram (
    .clk    (clk),
    .wr_en  (tag_we),
    .wr_addr(tag_waddr),
    .wr_data(tag_wdata),
    .rd_en  (tag_re),
    .rd_addr(set_in),
    .rd_data(tag_rdata)
  );

  slsd_ram #(
    .WIDTH(CNT_W),
    .DEPTH(WAYS)
  ) u_hit_ram (
    .clk    (clk),
    .wr_en  (hit_we),
    .wr_addr(hit_waddr),
    .wr_data(hit_wdata),
    .rd_en  (hit_re),
    .rd_addr(hit_raddr),
    .rd_data(hit_rdata)
  );

  slsd_set_lru #(
    .WAYS(WAYS)
  ) u_set_lru (
    .row_in   (tag_rdata),
    .line_addr(addr_r),
    .hit      (lk_hit),
    .pos      (lk_pos),
    .vic      (lk_vic),
    .row_out  (lk_row)
  );

  assign pos_ext = 32'(lk_pos);
  assign k_ext   = 32'(cnt_r);

  always_comb begin
    nsmp_res      = '0;
    nsmp_res.kind = KIND_ACCESS;
    nsmp_res.last = 1'b1;

    lk_res                = '0;
    lk_res.kind           = KIND_ACCESS;
    lk_res.sampled        = 1'b1;
    lk_res.hit            = lk_hit;
    lk_res.stack_position = lk_hit ? pos_ext[3:0] : 4'd0;
    lk_res.last           = 1'b1;

    curve_res             = '0;
    curve_res.kind        = KIND_CURVE;
    curve_res.curve_index = k_ext[4:0];
    curve_res.curve_value = (rem_r > TW'(CNT_MAX)) ? CNT_MAX : rem_r[CNT_W-1:0];
    curve_res.last        = (cnt_r == K_LAST);
  end

  always_comb begin
    state_nxt = state_r;
    init_nxt  = init_r;
    miss_nxt  = miss_r;
    hvld_nxt  = hvld_r;
    cnt_nxt   = cnt_r;
    rem_nxt   = rem_r;
    addr_nxt  = addr_r;
    set_nxt   = set_r;
    pos_nxt   = pos_r;
    res_nxt   = res_r;
    emit      = 1'b0;
    emit_data = res_r;
    tag_we    = 1'b0;
    tag_re    = 1'b0;
    tag_waddr = set_r;
    tag_wdata = lk_row;
    hit_we    = 1'b0;
    hit_re    = 1'b0;
    hit_waddr = pos_r;
    hit_wdata = (hval == CNT_MAX) ? CNT_MAX : hval + CNT_W'(1);
    hit_raddr = lk_pos;

    unique case (state_r)
      ST_INIT: begin
        tag_we    = 1'b1;
        tag_waddr = init_r;
        tag_wdata = init_row;
        init_nxt  = init_r + SAW'(1);
        if (init_r == INIT_END) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_accept) begin
          addr_nxt = in_data.line_addr;
          set_nxt  = set_in;
          unique case (op_in)
            OP_ACCESS: begin
              if (smp_in) begin
                tag_re    = 1'b1;
                state_nxt = ST_LOOKUP;
              end else if (out_free) begin
                emit      = 1'b1;
                emit_data = nsmp_res;
              end else begin
                res_nxt   = nsmp_res;
                state_nxt = ST_EMIT;
              end
            end
            OP_READ_CURVE: begin
              cnt_nxt   = '0;
              rem_nxt   = TW'(miss_r);
              state_nxt = ST_CSUM;
            end
            OP_CLEAR: begin
              hvld_nxt = '0;
              miss_nxt = '0;
            end
            default: begin
            end
          endcase
        end
      end
      ST_LOOKUP: begin
        tag_we = 1'b1;
        if (lk_hit) begin
          hit_re    = 1'b1;
          pos_nxt   = lk_pos;
          res_nxt   = lk_res;
          state_nxt = ST_HUPD;
        end else begin
          miss_nxt = (miss_r == CNT_MAX) ? CNT_MAX : miss_r + CNT_W'(1);
          if (out_free) begin
            emit      = 1'b1;
            emit_data = lk_res;
            state_nxt = ST_IDLE;
          end else begin
            res_nxt   = lk_res;
            state_nxt = ST_EMIT;
          end
        end
      end
      ST_HUPD: begin
        hit_we          = 1'b1;
        hvld_nxt[pos_r] = 1'b1;
        if (out_free) begin
          emit      = 1'b1;
          state_nxt = ST_IDLE;
        end else begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          emit      = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      ST_CSUM: begin
        if (cnt_r != '0) begin
          rem_nxt = rem_r + TW'(hval);
        end
        hit_re = 1'b1;
        if (cnt_r == K_LAST) begin
          hit_raddr = '0;
          cnt_nxt   = '0;
          state_nxt = ST_CEMIT;
        end else begin
          hit_raddr = cnt_r[PW-1:0];
          cnt_nxt   = cnt_r + KW'(1);
        end
      end
      ST_CEMIT: begin
        emit_data = curve_res;
        hit_raddr = cnt_r[PW-1:0];
        hit_re    = (cnt_r < K_LAST);
        if (out_free) begin
          emit = 1'b1;
          if (cnt_r == K_LAST) begin
            state_nxt = ST_IDLE;
          end else begin
            rem_nxt   = rem_r - TW'(hval);
            cnt_nxt   = cnt_r + KW'(1);
            hit_raddr = cnt_nxt[PW-1:0];
            hit_re    = (cnt_nxt < K_LAST);
          end
        end
      end
      default: begin
        state_nxt = ST_INIT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_INIT;
      init_r      <= '0;
      samp_bits_r <= '0;
      miss_r      <= '0;
      hvld_r      <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      init_r      <= init_nxt;
      samp_bits_r <= samp_bits_nxt;
      miss_r      <= miss_nxt;
      hvld_r      <= hvld_nxt;
      cnt_r       <= cnt_nxt;
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    rem_r  <= rem_nxt;
    addr_r <= addr_nxt;
    set_r  <= set_nxt;
    pos_r  <= pos_nxt;
    res_r  <= res_nxt;
    if (hit_re) begin
      hit_ra_r <= hit_raddr;
    end
    if (emit) begin
      out_data_r <= emit_data;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `SLSD_ASSERT_IMP(a_vic_onehot, state_r == ST_LOOKUP, $onehot(lk_vic), "victim not one-hot")
  `SLSD_ASSERT_NXT(a_access_lookup, in_accept && (op_in == OP_ACCESS) && smp_in, state_r == ST_LOOKUP, "sampled access skipped lookup")
  `SLSD_ASSERT_IMP(a_rem_nonneg, (state_r == ST_CEMIT) && emit && (cnt_r != K_LAST), rem_r >= TW'(hval), "curve remainder underflow")
  `SLSD_ASSERT_IMP(a_curve_last, emit && (emit_data.kind == KIND_CURVE) && emit_data.last, cnt_r == K_LAST, "curve last on wrong entry")

endmodule

@@ rtl/slsd_ram.sv @@
`timescale 1ns / 1ps
// Generic single-write, single-read synchronous RAM with registered read data.
module slsd_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

@@ rtl/slsd_set_lru.sv @@
`timescale 1ns / 1ps
// Tag compare, stack position search and LRU row update for one shadow set.
module slsd_set_lru
  import slsd_pkg::*;
#(
  parameter int unsigned WAYS = 16,
  localparam int unsigned PW = $clog2(WAYS),
  localparam int unsigned ROW_W = WAYS * (TAG_W + PW)
) (
  input  logic [ROW_W-1:0] row_in,
  input  logic [TAG_W-1:0] line_addr,
  output logic             hit,
  output logic [PW-1:0]    pos,
  output logic [WAYS-1:0]  vic,
  output logic [ROW_W-1:0] row_out
);

  localparam int unsigned RB = WAYS * TAG_W;

  logic [TAG_W-1:0] tag [WAYS];
  logic [PW-1:0]    rank [WAYS];
  logic [WAYS-1:0]  match;
  logic [WAYS-1:0]  match_by_rank;

  always_comb begin
    for (int w = 0; w < WAYS; w++) begin
      tag[w]   = row_in[w*TAG_W +: TAG_W];
      rank[w]  = row_in[RB + w*PW +: PW];
      match[w] = (tag[w] == line_addr);
    end
  end

  always_comb begin
    match_by_rank = '0;
    for (int r = 0; r < WAYS; r++) begin
      for (int w = 0; w < WAYS; w++) begin
        if (match[w] && (rank[w] == PW'(r))) begin
          match_by_rank[r] = 1'b1;
        end
      end
    end
  end

  assign hit = |match;

  // nearest MRU match wins; a miss takes the LRU position
  always_comb begin
    pos = PW'(WAYS - 1);
    for (int r = WAYS - 1; r >= 0; r--) begin
      if (match_by_rank[r]) begin
        pos = PW'(r);
      end
    end
  end

  always_comb begin
    row_out = row_in;
    for (int w = 0; w < WAYS; w++) begin
      vic[w] = (rank[w] == pos);
      if (vic[w]) begin
        row_out[w*TAG_W +: TAG_W] = line_addr;
        row_out[RB + w*PW +: PW]  = '0;
      end else if (rank[w] < pos) begin
        row_out[RB + w*PW +: PW]  = rank[w] + PW'(1);
      end
    end
  end

endmodule
